### hdl/fpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

    typedef struct packed {
        logic [7:0]  fmt_char;
        logic [63:0] arg_word;
    } item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } result_t;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_NUM  = 1'b1;

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    localparam logic [1:0] WID_8  = 2'd0;
    localparam logic [1:0] WID_16 = 2'd1;
    localparam logic [1:0] WID_32 = 2'd2;
    localparam logic [1:0] WID_64 = 2'd3;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2d;

    // one unit of work for the back end
    typedef struct packed {
        logic        kind;
        logic [7:0]  ch;
        logic [63:0] value;
        logic [1:0]  base;
        logic [1:0]  wid;
        logic        upper;
        logic        neg;
    } cmd_t;

endpackage

`default_nettype wire

### hdl/fpr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fpr_front
    import fpr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t item,
    input  wire logic  push,
    input  wire logic  q_full,
    output logic       full,
    output logic       cmd_valid,
    output cmd_t       cmd
);

    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_SPEC = 2'd1;
    localparam logic [1:0] MODE_H    = 2'd2;
    localparam logic [1:0] MODE_L    = 2'd3;

    localparam logic [2:0] LEN_HH  = 3'd0;
    localparam logic [2:0] LEN_H   = 3'd1;
    localparam logic [2:0] LEN_DEF = 3'd2;
    localparam logic [2:0] LEN_L   = 3'd3;
    localparam logic [2:0] LEN_LL  = 3'd4;

    localparam logic [7:0] CH_LC_H = "h";
    localparam logic [7:0] CH_LC_L = "l";
    localparam logic [7:0] CH_LC_C = "c";
    localparam logic [7:0] CH_LC_D = "d";
    localparam logic [7:0] CH_LC_I = "i";
    localparam logic [7:0] CH_LC_U = "u";
    localparam logic [7:0] CH_LC_O = "o";
    localparam logic [7:0] CH_LC_X = "x";
    localparam logic [7:0] CH_LC_P = "p";
    localparam logic [7:0] CH_UC_X = "X";

    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  len_reg, len_next;
    logic        accept;
    logic        cmd_gen;
    logic [7:0]  c;
    logic [63:0] a;
    logic [1:0]  wid;
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] mag;
    logic        sbit;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign c      = item.fmt_char;
    assign a      = item.arg_word;

    always_comb
    begin
        case (len_reg)
            LEN_HH:  wid = WID_8;
            LEN_H:   wid = WID_16;
            LEN_DEF: wid = WID_32;
            default: wid = WID_64;
        endcase
    end

    always_comb
    begin
        case (wid)
            WID_8:
            begin
                mask = 64'h0000_0000_0000_00ff;
                sbit = a[7];
            end
            WID_16:
            begin
                mask = 64'h0000_0000_0000_ffff;
                sbit = a[15];
            end
            WID_32:
            begin
                mask = 64'h0000_0000_ffff_ffff;
                sbit = a[31];
            end
            default:
            begin
                mask = 64'hffff_ffff_ffff_ffff;
                sbit = a[63];
            end
        endcase
    end

    assign v   = a & mask;
    assign mag = (64'd0 - v) & mask;

    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        cmd_gen   = 1'b0;
        cmd.kind  = KIND_CHAR;
        cmd.ch    = c;
        cmd.value = v;
        cmd.base  = BASE_DEC;
        cmd.wid   = wid;
        cmd.upper = 1'b0;
        cmd.neg   = 1'b0;
        if (c == 8'd0)
        begin
            mode_next = MODE_TEXT;
            len_next  = LEN_DEF;
        end
        else if (mode_reg == MODE_TEXT)
        begin
            if (c == CH_PERCENT)
                mode_next = MODE_SPEC;
            else
                cmd_gen = 1'b1;
        end
        else if (mode_reg == MODE_H && c == CH_LC_H)
        begin
            len_next  = LEN_HH;
            mode_next = MODE_SPEC;
        end
        else if (mode_reg == MODE_L && c == CH_LC_L)
        begin
            len_next  = LEN_LL;
            mode_next = MODE_SPEC;
        end
        else if (c == CH_LC_H)
        begin
            len_next  = LEN_H;
            mode_next = MODE_H;
        end
        else if (c == CH_LC_L)
        begin
            len_next  = LEN_L;
            mode_next = MODE_L;
        end
        else
        begin
            mode_next = MODE_TEXT;
            len_next  = LEN_DEF;
            case (c)
                CH_PERCENT:
                begin
                    cmd_gen = 1'b1;
                    cmd.ch  = CH_PERCENT;
                end
                CH_LC_C:
                begin
                    cmd_gen = 1'b1;
                    cmd.ch  = a[7:0];
                end
                CH_LC_D, CH_LC_I:
                begin
                    cmd_gen  = 1'b1;
                    cmd.kind = KIND_NUM;
                    cmd.neg  = sbit;
                    if (sbit)
                        cmd.value = mag;
                end
                CH_LC_U:
                begin
                    cmd_gen  = 1'b1;
                    cmd.kind = KIND_NUM;
                end
                CH_LC_O:
                begin
                    cmd_gen  = 1'b1;
                    cmd.kind = KIND_NUM;
                    cmd.base = BASE_OCT;
                end
                CH_LC_X, CH_LC_P:
                begin
                    cmd_gen  = 1'b1;
                    cmd.kind = KIND_NUM;
                    cmd.base = BASE_HEX;
                end
                CH_UC_X:
                begin
                    cmd_gen   = 1'b1;
                    cmd.kind  = KIND_NUM;
                    cmd.base  = BASE_HEX;
                    cmd.upper = 1'b1;
                end
                default:
                begin
                    cmd_gen = 1'b0;
                end
            endcase
        end
    end

    assign cmd_valid = accept && cmd_gen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TEXT;
            len_reg  <= LEN_DEF;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
        end
    end

endmodule

`default_nettype wire

### hdl/fpr_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module fpr_cmd_fifo
    import fpr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      empty
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_wr;
    logic       do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("command queue count out of range");
`endif

endmodule

`default_nettype wire

### hdl/fpr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fpr_back
    import fpr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_avail,
    input  wire cmd_t cmd,
    output logic      cmd_pop,
    output result_t   result,
    output logic      empty,
    input  wire logic pop
);

    localparam int NDIG = 22;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHAR   = 3'd1;
    localparam logic [2:0] ST_DABBLE = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [NDIG-1:0][3:0]  dig_reg, dig_next;
    logic [63:0]           val_reg, val_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic                  upper_reg, upper_next;
    logic [7:0]            ch_reg, ch_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;
    logic                  out_ok;
    logic                  emit;
    result_t               emit_data;
    logic [65:0]           oct_ext;
    logic [NDIG*4-1:0]     hex_ext;
    logic [NDIG-1:0][3:0]  load_dig;
    logic [4:0]            msd_idx;

    // four shift-and-add-3 steps of binary to BCD
    function automatic logic [NDIG-1:0][3:0] dabble4(
        input logic [NDIG-1:0][3:0] d_in,
        input logic [3:0]           bits
    );
        logic [NDIG-1:0][3:0] d;
        logic [NDIG*4:0]      sh;
        d = d_in;
        for (int s = 0; s < 4; s++)
        begin
            for (int k = 0; k < NDIG; k++)
            begin
                if (d[k] >= 4'd5)
                    d[k] = d[k] + 4'd3;
            end
            sh = {d, bits[3-s]};
            d  = sh[NDIG*4-1:0];
        end
        return d;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
        logic [7:0] r;
        if (d < 4'd10)
            r = 8'h30 + {4'd0, d};
        else if (up)
            r = 8'h37 + {4'd0, d};
        else
            r = 8'h57 + {4'd0, d};
        return r;
    endfunction

    assign oct_ext = {2'b00, cmd.value};
    assign hex_ext = {{(NDIG*4-64){1'b0}}, cmd.value};

    always_comb
    begin
        for (int k = 0; k < NDIG; k++)
        begin
            if (cmd.base == BASE_OCT)
                load_dig[k] = {1'b0, oct_ext[3*k +: 3]};
            else
                load_dig[k] = hex_ext[4*k +: 4];
        end
    end

    always_comb
    begin
        msd_idx = 5'd0;
        for (int k = 0; k < NDIG; k++)
        begin
            if (dig_reg[k] != 4'd0)
                msd_idx = 5'(k);
        end
    end

    assign out_ok = !out_valid_reg || pop;

    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        upper_next = upper_reg;
        ch_next    = ch_reg;
        cmd_pop    = 1'b0;
        emit       = 1'b0;
        emit_data.out_char    = ch_reg;
        emit_data.last_of_run = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_avail)
                begin
                    cmd_pop    = 1'b1;
                    ch_next    = cmd.ch;
                    neg_next   = cmd.neg;
                    upper_next = cmd.upper;
                    if (cmd.kind == KIND_CHAR)
                        state_next = ST_CHAR;
                    else if (cmd.base == BASE_DEC)
                    begin
                        dig_next   = '0;
                        state_next = ST_DABBLE;
                        case (cmd.wid)
                            WID_8:
                            begin
                                val_next = cmd.value << 56;
                                cnt_next = 5'd1;
                            end
                            WID_16:
                            begin
                                val_next = cmd.value << 48;
                                cnt_next = 5'd3;
                            end
                            WID_32:
                            begin
                                val_next = cmd.value << 32;
                                cnt_next = 5'd7;
                            end
                            default:
                            begin
                                val_next = cmd.value;
                                cnt_next = 5'd15;
                            end
                        endcase
                    end
                    else
                    begin
                        dig_next   = load_dig;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_CHAR:
            begin
                if (out_ok)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DABBLE:
            begin
                dig_next = dabble4(dig_reg, val_reg[63:60]);
                val_next = {val_reg[59:0], 4'd0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cnt_next   = msd_idx;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ok)
                begin
                    emit = 1'b1;
                    if (neg_reg)
                    begin
                        emit_data.out_char    = CH_MINUS;
                        emit_data.last_of_run = 1'b0;
                        neg_next              = 1'b0;
                    end
                    else
                    begin
                        emit_data.out_char    = digit_char(dig_reg[cnt_reg], upper_reg);
                        emit_data.last_of_run = (cnt_reg == 5'd0);
                        if (cnt_reg == 5'd0)
                            state_next = ST_IDLE;
                        else
                            cnt_next = cnt_reg - 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_data;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg   <= dig_next;
        val_reg   <= val_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        upper_reg <= upper_next;
        ch_reg    <= ch_next;
        out_reg   <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_dabble_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DABBLE && cnt_reg == 5'd0) |=> state_reg == ST_SCAN)
        else $error("BCD conversion did not finish on count");

    a_scan_msd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |=> (cnt_reg == 5'd0 || dig_reg[cnt_reg] != 4'd0))
        else $error("leading digit is zero");

    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> cnt_reg < 5'(NDIG))
        else $error("digit index out of range");
`endif

endmodule

`default_nettype wire

### hdl/format_string_integer_printer_core.sv
// A plain character passes the queue, back-end IDLE and CHAR states, then out_reg.
// Numbers: fetch, BCD conversion for decimal (4 bits per cycle), a leading-digit
// scan, then one character per cycle while the output register is free or popped.
// Throughput: input taken once per cycle while the 2-entry command queue has room;
// the back end takes no new command until done (64-bit decimal: 20 characters).
// Reset (rst_n low, async): text mode, 32-bit length, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none

module format_string_integer_printer_core
    import fpr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t item,
    input  wire logic  push,
    output logic       full,
    output result_t    result,
    output logic       empty,
    input  wire logic  pop
);

    logic cmd_wr;
    cmd_t cmd_in;
    logic q_full;
    logic q_empty;
    logic cmd_rd;
    cmd_t cmd_out;

    fpr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .q_full    (q_full),
        .full      (full),
        .cmd_valid (cmd_wr),
        .cmd       (cmd_in)
    );

    fpr_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data (cmd_in),
        .full    (q_full),
        .rd_en   (cmd_rd),
        .rd_data (cmd_out),
        .empty   (q_empty)
    );

    fpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (!q_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_rd),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire
